// ----- hw/rtl/mmc_cartridge_spi_card_regs_defines.svh -----
//------------------------------------------------------------------------------
// mmc_cartridge_spi_card_regs_defines
// assertion macros for the card register block
//------------------------------------------------------------------------------
`ifndef MMC_CARTRIDGE_SPI_CARD_REGS_DEFINES_SVH
`define MMC_CARTRIDGE_SPI_CARD_REGS_DEFINES_SVH

// implication checked on every clock edge outside reset
`define MCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/mcr_pkg.sv -----
//------------------------------------------------------------------------------
// mcr_pkg
// shared constants and the reset reply function for the spi card register block
//------------------------------------------------------------------------------
package mcr_pkg;
	localparam int ADDRESS_BITS_DEF = 32;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_RESET  = 3'd1;
	localparam logic [2:0] MODE_INIT   = 3'd2;
	localparam logic [2:0] MODE_READ   = 3'd3;
	localparam logic [2:0] MODE_DREAD  = 3'd4;
	localparam logic [2:0] MODE_WRITE  = 3'd5;
	localparam logic [2:0] MODE_DWRITE = 3'd6;
	localparam logic [2:0] MODE_RETW   = 3'd7;

	localparam logic [1:0] REG_DATA    = 2'd0;
	localparam logic [1:0] REG_CONTROL = 2'd1;
	localparam logic [1:0] REG_STATUS  = 2'd2;
	localparam logic [1:0] REG_ID      = 2'd3;

	localparam logic [1:0] CFG_PRESENT  = 2'd0;
	localparam logic [1:0] CFG_PROTECT  = 2'd1;
	localparam logic [1:0] CFG_JUMPER   = 2'd2;
	localparam logic [1:0] CFG_REVISION = 2'd3;

	localparam logic [7:0] CMD_RESET = 8'h40;
	localparam logic [7:0] CMD_INIT  = 8'h41;
	localparam logic [7:0] CMD_IDLE  = 8'h4c;
	localparam logic [7:0] CMD_BLEN  = 8'h50;
	localparam logic [7:0] CMD_READ  = 8'h51;
	localparam logic [7:0] CMD_WRITE = 8'h58;

	localparam logic [7:0] TOKEN_START = 8'hfe;
	localparam logic [15:0] UNLOCK_ARM = 16'h55aa;
	localparam logic [15:0] UNLOCK_ENA = 16'h0a1c;
	localparam logic [7:0] ID_VALUE    = 8'h64;
	localparam logic [31:0] BLOCK_DEF  = 32'd512;

	function automatic logic [7:0] reset_reply(input logic [2:0] idx);
		unique case (idx)
			3'd1, 3'd2, 3'd4, 3'd5: reset_reply = 8'h01;
			default: reset_reply = 8'h00;
		endcase
	endfunction
endpackage

// ----- hw/rtl/mmc_cartridge_spi_card_regs.sv -----
//------------------------------------------------------------------------------
// mmc_cartridge_spi_card_regs
// spi memory card register block
//------------------------------------------------------------------------------
// One bus request per cycle while the output is not stalled: each accepted
// request is evaluated combinationally from the held register state and its
// result is captured in an output register. A request is taken whenever the
// output register is empty or being drained, so the block sustains that rate.
module mmc_cartridge_spi_card_regs #(
	parameter int ADDRESS_BITS = mcr_pkg::ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [1:0]  reg_select,
	input  logic [7:0]  write_data,
	input  logic [7:0]  storage_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [31:0] storage_address,
	output logic        storage_read,
	output logic        storage_write,
	output logic [7:0]  storage_write_data,
	output logic        exrom_line,
	output logic        bios_mapped,
	output logic        clockport_alternate,
	output logic        block_disabled
);
	import mcr_pkg::*;
	`include "mmc_cartridge_spi_card_regs_defines.svh"

	localparam logic [31:0] AMASK = 32'(({33'd0, 1'b1} << ADDRESS_BITS) - 34'd1);

	logic        present_q, protect_q, jumper_q, revision_q;
	logic [7:0]  ctrl_q;
	logic        armed_q;
	logic [15:0] hist_q;
	logic [7:0]  cmd_q [10];
	logic [3:0]  cnt_q;
	logic [2:0]  mode_q;
	logic [2:0]  rri_q;
	logic [32:0] rpos_q;
	logic [31:0] blen_q;
	logic [1:0]  wph_q;
	logic [31:0] wcnt_q;
	logic [31:0] ptr_q;
	logic        exrom_q;

	logic [7:0]  ctrl_n;
	logic        armed_n;
	logic [15:0] hist_n;
	logic [7:0]  cmd_n [10];
	logic [3:0]  cnt_n;
	logic [2:0]  mode_n;
	logic [2:0]  rri_n;
	logic [32:0] rpos_n;
	logic [31:0] blen_n;
	logic [1:0]  wph_n;
	logic [31:0] wcnt_n;
	logic [31:0] ptr_n;
	logic        exrom_n;
	logic [7:0]  rd;
	logic        cons, swr;
	logic [7:0]  swd;
	logic        acc;

	logic [31:0] cword;
	logic [7:0]  nb;
	logic [32:0] bl33, rp;
	logic [15:0] hcat;
	logic [4:0]  cnt5;

	assign acc       = in_valid && !in_stall;
	assign in_stall  = out_valid && out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		ctrl_n = ctrl_q; armed_n = armed_q; hist_n = hist_q; cmd_n = cmd_q;
		cnt_n = cnt_q; mode_n = mode_q; rri_n = rri_q; rpos_n = rpos_q;
		blen_n = blen_q; wph_n = wph_q; wcnt_n = wcnt_q; ptr_n = ptr_q;
		exrom_n = exrom_q; rd = 8'h00; cons = 1'b0; swr = 1'b0; swd = 8'h00;
		cword = 32'h0; nb = 8'h00; bl33 = {1'b0, blen_q}; rp = rpos_q;
		hcat = 16'h0; cnt5 = 5'd0;
		if (action) begin
			unique case (reg_select)
				REG_DATA: begin
					if (!ctrl_q[7]) begin
						if (mode_q == MODE_WRITE || mode_q == MODE_DWRITE) begin
							unique case (wph_q)
								2'd0: begin
									if (write_data == TOKEN_START) begin
										wph_n = 2'd1; wcnt_n = 32'd0;
									end
								end
								2'd1: begin
									if (mode_q == MODE_WRITE) begin
										swr = 1'b1; swd = write_data;
										ptr_n = (ptr_q + 32'd1) & AMASK;
									end
									wcnt_n = wcnt_q + 32'd1;
									if (wcnt_n == blen_q)
										wph_n = 2'd2;
								end
								2'd2: wph_n = 2'd3;
								default: mode_n = MODE_RETW;
							endcase
						end else if (cnt_q == 4'd0 && write_data != 8'hff) begin
						end else if (cnt_q == 4'd1 && write_data == 8'hff) begin
							cnt_n = 4'd0;
						end else begin
							if (cnt_q < 4'd10)
								cmd_n[cnt_q] = write_data;
							cnt5 = {1'b0, cnt_q} + 5'd1;
							cnt_n = cnt5[3:0];
							if (cnt5 > 5'd9 || (cnt5 > 5'd8 && cmd_n[1] == CMD_BLEN)) begin
								cword = {cmd_n[2], cmd_n[3], cmd_n[4], cmd_n[5]};
								unique case (cmd_n[1])
									CMD_RESET: begin
										ctrl_n = 8'h00; rri_n = 3'd0; wcnt_n = 32'd0;
										blen_n = BLOCK_DEF; exrom_n = 1'b1;
										mode_n = MODE_RESET;
									end
									CMD_INIT: mode_n = MODE_INIT;
									CMD_IDLE: mode_n = MODE_IDLE;
									CMD_BLEN: begin
										mode_n = MODE_IDLE; blen_n = cword;
									end
									CMD_READ: begin
										rpos_n = 33'd0;
										if (present_q) begin
											mode_n = MODE_READ; ptr_n = cword & AMASK;
										end else
											mode_n = MODE_DREAD;
									end
									CMD_WRITE: begin
										wph_n = 2'd0;
										if (present_q && blen_q != 32'd0) begin
											ptr_n = cword & AMASK;
											mode_n = protect_q ? MODE_DWRITE : MODE_WRITE;
										end else
											mode_n = MODE_DWRITE;
									end
									default: ;
								endcase
								for (int i = 0; i < 10; i++)
									cmd_n[i] = 8'h00;
								cnt_n = 4'd0;
							end
						end
					end
				end
				REG_CONTROL: begin
					if (!ctrl_q[7]) begin
						nb = write_data & 8'h6f;
						if (armed_q && write_data[7])
							nb[7] = 1'b1;
						armed_n = 1'b0;
						nb[4] = jumper_q ? write_data[4] : ctrl_q[4];
						ctrl_n = nb;
						exrom_n = !nb[0];
					end
				end
				REG_ID: begin
					hcat = {hist_q[7:0], write_data};
					hist_n = hcat;
					if (hcat == UNLOCK_ARM)
						armed_n = 1'b1;
					if (hcat == UNLOCK_ENA) begin
						ctrl_n[7] = 1'b0; exrom_n = 1'b1;
					end
				end
				default: ;
			endcase
		end else begin
			unique case (reg_select)
				REG_DATA: begin
					unique case (mode_q)
						MODE_RETW: begin
							mode_n = MODE_IDLE; rd = 8'hff;
						end
						MODE_RESET: begin
							if (rri_q > 3'd5) begin
								rri_n = 3'd0;
							end else begin
								rd = reset_reply(rri_q);
								rri_n = (rri_q == 3'd5) ? 3'd0 : rri_q + 3'd1;
							end
						end
						MODE_READ, MODE_DREAD: begin
							if (ctrl_q[6]) begin
								if (rpos_q != bl33 + 33'd5)
									rp = rpos_q + 33'd1;
							end else begin
								if (rpos_q != bl33 + 33'd2)
									rp = rpos_q + 33'd1;
							end
							rpos_n = rp;
							if (ctrl_q[6] && rp == bl33 + 33'd3) rd = 8'h00;
							else if (ctrl_q[6] && rp == bl33 + 33'd4) rd = 8'h01;
							else if (ctrl_q[6] && rp == bl33 + 33'd5) rd = 8'h00;
							else if (!ctrl_q[6] && rp == bl33 + 33'd1) rd = 8'h00;
							else if (!ctrl_q[6] && rp == bl33 + 33'd2) rd = 8'h01;
							else if (rp == 33'd1) rd = TOKEN_START;
							else if (rp == 33'd2 && ctrl_q[6]) rd = TOKEN_START;
							else if (present_q && mode_q != MODE_DREAD) begin
								cons = 1'b1; rd = storage_byte;
								ptr_n = (ptr_q + 32'd1) & AMASK;
							end
						end
						default: ;
					endcase
				end
				REG_CONTROL: rd = ctrl_q;
				REG_STATUS: rd = {2'b00, jumper_q, protect_q, !present_q, 3'b110};
				default: rd = !ctrl_q[1] ? ID_VALUE : (revision_q ? 8'd2 : 8'd1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b1; protect_q <= 1'b0; jumper_q <= 1'b0; revision_q <= 1'b0;
			ctrl_q <= 8'h00; armed_q <= 1'b0; hist_q <= 16'h0;
			for (int i = 0; i < 10; i++)
				cmd_q[i] <= 8'h00;
			cnt_q <= 4'd0; mode_q <= MODE_IDLE; rri_q <= 3'd0; rpos_q <= 33'd0;
			blen_q <= BLOCK_DEF; wph_q <= 2'd0; wcnt_q <= 32'd0; ptr_q <= 32'd0;
			exrom_q <= 1'b1; out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PRESENT:  present_q <= cfg_data[0];
					CFG_PROTECT:  protect_q <= cfg_data[0];
					CFG_JUMPER:   jumper_q <= cfg_data[0];
					default:      revision_q <= cfg_data[0];
				endcase
			end
			if (acc) begin
				ctrl_q <= ctrl_n; armed_q <= armed_n; hist_q <= hist_n; cmd_q <= cmd_n;
				cnt_q <= cnt_n; mode_q <= mode_n; rri_q <= rri_n; rpos_q <= rpos_n;
				blen_q <= blen_n; wph_q <= wph_n; wcnt_q <= wcnt_n; ptr_q <= ptr_n;
				exrom_q <= exrom_n;
			end
			if (!in_stall)
				out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_data <= rd; storage_address <= ptr_q; storage_read <= cons;
			storage_write <= swr; storage_write_data <= swd; exrom_line <= exrom_n;
			bios_mapped <= !ctrl_n[7] && !ctrl_n[0];
			clockport_alternate <= ctrl_n[3]; block_disabled <= ctrl_n[7];
		end
	end

	`MCR_ASSERT_IMP(a_stall_hold, clk, arst_n, out_valid && out_stall, in_stall)
	`MCR_ASSERT_IMP(a_rw_excl, clk, arst_n, out_valid, !(storage_read && storage_write))
	`MCR_ASSERT_NEXT(a_ptr_mask, clk, arst_n, 1'b1, (ptr_q & ~AMASK) == 32'd0)
	`MCR_ASSERT_NEXT(a_cnt_range, clk, arst_n, 1'b1, cnt_q < 4'd10)
endmodule

// ----- dv/mmc_cartridge_spi_card_regs_tb.sv -----
//------------------------------------------------------------------------------
// mmc_cartridge_spi_card_regs_tb
// Self-checking bench for the spi card register block. Bus requests are driven
// through the valid/stall channel, each one is run through a local model of
// the card (command assembler, reset replies, framed block reads, block
// writes, unlock sequence) and every result is compared field by field.
// The card configuration changes between phases while the block is idle.
//------------------------------------------------------------------------------
module mmc_cartridge_spi_card_regs_tb;
	import mcr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic       action;
		logic [1:0] sel;
		logic [7:0] wdata;
		logic [7:0] sbyte;
	} bus_req_t;

	typedef struct packed {
		logic [7:0]  rdata;
		logic [31:0] addr;
		logic        srd;
		logic        swr;
		logic [7:0]  swdata;
		logic        exrom;
		logic        bios;
		logic        cport;
		logic        disabled;
	} bus_resp_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic action;
	logic [1:0] reg_select;
	logic [7:0] write_data, storage_byte;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic out_valid, out_stall;
	logic [7:0] read_data;
	logic [31:0] storage_address;
	logic storage_read, storage_write;
	logic [7:0] storage_write_data;
	logic exrom_line, bios_mapped, clockport_alternate, block_disabled;

	mmc_cartridge_spi_card_regs uut (.*);

	// card model state
	logic       card_present, card_protect, card_jumper, card_rev;
	logic [7:0] ctrl_q;
	logic       armed_q;
	logic [15:0] unlock_q;
	logic [7:0] cmd_q [10];
	logic [3:0] cmd_cnt;
	logic [2:0] mode_q;
	logic [2:0] reply_idx;
	longint     rd_pos;
	logic [31:0] blk_len;
	logic [1:0] wr_phase;
	logic [31:0] wr_cnt;
	logic [31:0] sptr;
	logic       exrom_q;
	logic       st_wr;
	logic [7:0] st_wr_byte;

	bus_req_t  pending_reqs[$];
	bus_resp_t expected_resps[$];
	int errors = 0;
	int n_reqs = 0, n_resps = 0, n_storage_rd = 0, n_storage_wr = 0;
	int watchdog = 0;
	bit no_idle = 0;
	int send_gap = 0, stall_gap = 0;
	int gen_blen;

	function automatic logic [31:0] cmd_word();
		return {cmd_q[2], cmd_q[3], cmd_q[4], cmd_q[5]};
	endfunction

	task automatic clear_cmd();
		for (int i = 0; i < 10; i++) cmd_q[i] = '0;
		cmd_cnt = 0;
	endtask

	task automatic card_reset();
		ctrl_q = 0; armed_q = 0; unlock_q = 0;
		clear_cmd();
		mode_q = MODE_IDLE; reply_idx = 0; rd_pos = 0; blk_len = BLOCK_DEF;
		wr_phase = 0; wr_cnt = 0; sptr = 0; exrom_q = 1;
	endtask

	task automatic run_command();
		case (cmd_q[1])
			CMD_RESET: begin
				ctrl_q = 0; reply_idx = 0; wr_cnt = 0; blk_len = BLOCK_DEF;
				exrom_q = 1; mode_q = MODE_RESET;
			end
			CMD_INIT: mode_q = MODE_INIT;
			CMD_IDLE: mode_q = MODE_IDLE;
			CMD_BLEN: begin
				mode_q = MODE_IDLE;
				blk_len = cmd_word();
			end
			CMD_READ: begin
				rd_pos = 0;
				if (card_present) begin
					mode_q = MODE_READ;
					sptr = cmd_word();
				end else
					mode_q = MODE_DREAD;
			end
			CMD_WRITE: begin
				wr_phase = 0;
				if (card_present && blk_len > 0) begin
					sptr = cmd_word();
					mode_q = card_protect ? MODE_DWRITE : MODE_WRITE;
				end else
					mode_q = MODE_DWRITE;
			end
			default: ;
		endcase
	endtask

	task automatic gather_byte(input logic [7:0] b);
		if (cmd_cnt == 0 && b != 8'hff) return;
		if (cmd_cnt == 1 && b == 8'hff) begin
			cmd_cnt = 0;
			return;
		end
		if (cmd_cnt < 10) cmd_q[cmd_cnt] = b;
		cmd_cnt++;
		if (cmd_cnt > 9 || (cmd_cnt > 8 && cmd_q[1] == CMD_BLEN)) begin
			run_command();
			clear_cmd();
		end
	endtask

	task automatic block_write_byte(input logic [7:0] b);
		case (wr_phase)
			2'd0: if (b == TOKEN_START) begin
				wr_phase = 1;
				wr_cnt = 0;
			end
			2'd1: begin
				if (mode_q == MODE_WRITE) begin
					st_wr = 1;
					st_wr_byte = b;
					sptr++;
				end
				wr_cnt++;
				if (wr_cnt == blk_len) wr_phase = 2;
			end
			2'd2: wr_phase = 3;
			default: mode_q = MODE_RETW;
		endcase
	endtask

	task automatic spi_data_read(input logic [7:0] sb, output logic [7:0] v,
			output logic used);
		longint bl;
		logic [7:0] replies [6];
		bl = longint'(blk_len);
		replies = '{8'h00, 8'h01, 8'h01, 8'h00, 8'h01, 8'h01};
		used = 0;
		v = 0;
		case (mode_q)
			MODE_RETW: begin
				mode_q = MODE_IDLE;
				v = 8'hff;
			end
			MODE_RESET: begin
				if (reply_idx > 5) reply_idx = 0;
				else begin
					v = replies[reply_idx];
					reply_idx = (reply_idx == 5) ? 3'd0 : reply_idx + 3'd1;
				end
			end
			MODE_READ, MODE_DREAD: begin
				if (ctrl_q[6]) begin
					if (rd_pos != bl + 5) rd_pos = (rd_pos + 1) & 64'h1_ffff_ffff;
				end else begin
					if (rd_pos != bl + 2) rd_pos = (rd_pos + 1) & 64'h1_ffff_ffff;
				end
				if (ctrl_q[6] && rd_pos == bl + 3) v = 8'h00;
				else if (ctrl_q[6] && rd_pos == bl + 4) v = 8'h01;
				else if (ctrl_q[6] && rd_pos == bl + 5) v = 8'h00;
				else if (!ctrl_q[6] && rd_pos == bl + 1) v = 8'h00;
				else if (!ctrl_q[6] && rd_pos == bl + 2) v = 8'h01;
				else if (rd_pos == 1) v = TOKEN_START;
				else if (rd_pos == 2 && ctrl_q[6]) v = TOKEN_START;
				else if (card_present && mode_q != MODE_DREAD) begin
					used = 1;
					sptr++;
					v = sb;
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_access(input bus_req_t r, output bus_resp_t e);
		logic [7:0] nb;
		logic [7:0] rd;
		logic used;
		rd = 0;
		used = 0;
		st_wr = 0;
		st_wr_byte = 0;
		e.addr = sptr;
		if (r.action) begin
			case (r.sel)
				REG_DATA: if (!ctrl_q[7]) begin
					if (mode_q == MODE_WRITE || mode_q == MODE_DWRITE)
						block_write_byte(r.wdata);
					else
						gather_byte(r.wdata);
				end
				REG_CONTROL: if (!ctrl_q[7]) begin
					nb = r.wdata & 8'h6f;
					if (armed_q && r.wdata[7]) nb[7] = 1;
					armed_q = 0;
					nb[4] = card_jumper ? r.wdata[4] : ctrl_q[4];
					ctrl_q = nb;
					exrom_q = !nb[0];
				end
				REG_ID: begin
					unlock_q = {unlock_q[7:0], r.wdata};
					if (unlock_q == UNLOCK_ARM) armed_q = 1;
					if (unlock_q == UNLOCK_ENA) begin
						ctrl_q[7] = 0;
						exrom_q = 1;
					end
				end
				default: ;
			endcase
		end else begin
			case (r.sel)
				REG_DATA: spi_data_read(r.sbyte, rd, used);
				REG_CONTROL: rd = ctrl_q;
				REG_STATUS: rd = {2'b00, card_jumper, card_protect, !card_present, 3'b110};
				default: rd = !ctrl_q[1] ? ID_VALUE : (card_rev ? 8'd2 : 8'd1);
			endcase
		end
		e.rdata = rd;
		e.srd = used;
		e.swr = st_wr;
		e.swdata = st_wr_byte;
		e.exrom = exrom_q;
		e.bios = !ctrl_q[7] && !ctrl_q[0];
		e.cport = ctrl_q[3];
		e.disabled = ctrl_q[7];
	endtask

	// stimulus helpers
	task automatic push_req(input logic act, input logic [1:0] sel, input logic [7:0] wd);
		bus_req_t r;
		r.action = act;
		r.sel = sel;
		r.wdata = wd;
		r.sbyte = 8'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic push_cmd(input logic [7:0] code, input logic [31:0] word);
		int len;
		len = (code == CMD_BLEN) ? 9 : 10;
		push_req(1, REG_DATA, 8'hff);
		push_req(1, REG_DATA, code);
		for (int i = 3; i >= 0; i--) push_req(1, REG_DATA, word[8*i +: 8]);
		for (int i = 6; i < len; i++) push_req(1, REG_DATA, 8'($urandom));
		if (code == CMD_RESET) gen_blen = 512;
		if (code == CMD_BLEN) gen_blen = int'(word);
	endtask

	task automatic push_data_reads(input int n);
		for (int i = 0; i < n; i++) push_req(0, REG_DATA, 8'($urandom));
	endtask

	function automatic int pick_gap();
		int k;
		if (no_idle) return 0;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic push_sequence();
		logic [31:0] w;
		int n;
		case ($urandom_range(0, 9))
			0: begin
				push_cmd(CMD_RESET, $urandom);
				push_data_reads($urandom_range(0, 8));
				push_cmd(CMD_BLEN, $urandom_range(0, 6));
			end
			1: begin
				push_cmd(CMD_INIT, $urandom);
				push_data_reads($urandom_range(1, 3));
				push_cmd(CMD_IDLE, $urandom);
				push_data_reads(1);
			end
			2: begin
				w = ($urandom_range(0, 9) == 0) ? 32'd16 : 32'($urandom_range(0, 6));
				push_cmd(CMD_BLEN, w);
			end
			3, 4: begin
				if ($urandom_range(0, 1))
					push_req(1, REG_CONTROL, 8'($urandom) & 8'h7f);
				push_cmd(CMD_READ, $urandom);
				n = (gen_blen > 40) ? 10 : gen_blen + $urandom_range(3, 8);
				push_data_reads(n);
			end
			5, 6: begin
				push_cmd(CMD_WRITE, $urandom);
				if ($urandom_range(0, 3) == 0) push_req(1, REG_DATA, 8'($urandom));
				push_req(1, REG_DATA, TOKEN_START);
				n = (gen_blen > 40) ? 40 : gen_blen;
				for (int i = 0; i < n + 3; i++) push_req(1, REG_DATA, 8'($urandom));
				push_data_reads($urandom_range(1, 2));
			end
			7: begin
				push_req(1, REG_CONTROL, 8'($urandom) & 8'h7f);
				push_req(0, REG_CONTROL, 0);
				push_req(0, REG_ID, 0);
				push_req(0, REG_STATUS, 0);
			end
			8: begin
				push_req(1, REG_ID, UNLOCK_ARM[15:8]);
				push_req(1, REG_ID, UNLOCK_ARM[7:0]);
				push_req(1, REG_CONTROL, 8'($urandom) | 8'h80);
				for (int i = 0; i < 4; i++)
					push_req(1'($urandom_range(0, 1)), 2'($urandom), 8'($urandom));
				push_req(1, REG_ID, UNLOCK_ENA[15:8]);
				push_req(1, REG_ID, UNLOCK_ENA[7:0]);
			end
			default: begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_req(1'($urandom_range(0, 1)), 2'($urandom), 8'($urandom));
			end
		endcase
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= {7'b0, val};
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PRESENT: card_present = val;
			CFG_PROTECT: card_protect = val;
			CFG_JUMPER: card_jumper = val;
			default: card_rev = val;
		endcase
		cfg_valid <= 0;
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (pending_reqs.size() != 0 || in_valid ||
			expected_resps.size() != 0);
		repeat (5) @(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		bus_resp_t e;
		logic took;
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			took = in_valid && !in_stall;
			if (took) begin
				predict_access(pending_reqs.pop_front(), e);
				expected_resps.push_back(e);
				n_reqs++;
				send_gap = pick_gap();
			end
			if (in_valid && !took) begin
			end else if (send_gap > 0 || pending_reqs.size() == 0) begin
				in_valid <= 0;
				if (send_gap > 0) send_gap--;
			end else begin
				in_valid <= 1;
				action <= pending_reqs[0].action;
				reg_select <= pending_reqs[0].sel;
				write_data <= pending_reqs[0].wdata;
				storage_byte <= pending_reqs[0].sbyte;
			end
		end
	end

	// result monitor, output stall and watchdog
	always @(posedge clk or negedge arst_n) begin
		bus_resp_t e;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_resps++;
				if (expected_resps.size() == 0) begin
					$error("result with no request waiting");
					errors++;
				end else begin
					e = expected_resps.pop_front();
					if (read_data !== e.rdata) begin
						$error("read_data exp %h got %h", e.rdata, read_data); errors++;
					end
					if (storage_address !== e.addr) begin
						$error("storage_address exp %h got %h", e.addr, storage_address);
						errors++;
					end
					if (storage_read !== e.srd) begin
						$error("storage_read exp %b got %b", e.srd, storage_read); errors++;
					end
					if (storage_write !== e.swr) begin
						$error("storage_write exp %b got %b", e.swr, storage_write); errors++;
					end
					if (storage_write_data !== e.swdata) begin
						$error("storage_write_data exp %h got %h", e.swdata,
							storage_write_data);
						errors++;
					end
					if (exrom_line !== e.exrom) begin
						$error("exrom_line exp %b got %b", e.exrom, exrom_line); errors++;
					end
					if (bios_mapped !== e.bios) begin
						$error("bios_mapped exp %b got %b", e.bios, bios_mapped); errors++;
					end
					if (clockport_alternate !== e.cport) begin
						$error("clockport_alternate exp %b got %b", e.cport,
							clockport_alternate);
						errors++;
					end
					if (block_disabled !== e.disabled) begin
						$error("block_disabled exp %b got %b", e.disabled, block_disabled);
						errors++;
					end
					n_storage_rd += e.srd;
					n_storage_wr += e.swr;
				end
			end
			if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1;
			end else begin
				stall_gap = pick_gap();
				out_stall <= (stall_gap > 0);
				if (stall_gap > 0) stall_gap--;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				watchdog = 0;
			else if (++watchdog >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0] settings [6];
		settings = '{4'b1000, 4'b1111, 4'b0010, 4'b1011, 4'b0101, 4'b1000};
		arst_n = 0;
		in_valid = 0; action = 0; reg_select = 0; write_data = 0; storage_byte = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		out_stall = 0;
		card_present = 1; card_protect = 0; card_jumper = 0; card_rev = 0;
		card_reset();
		gen_blen = 512;
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed opening
		push_req(0, REG_STATUS, 0);
		push_req(0, REG_ID, 0);
		push_req(0, REG_DATA, 0);
		push_req(1, REG_DATA, 8'h00);
		push_req(1, REG_STATUS, 8'hff);
		push_req(1, REG_CONTROL, 8'hff);
		push_req(0, REG_CONTROL, 0);
		push_req(0, REG_ID, 0);
		push_req(1, REG_DATA, 8'hff);
		push_req(1, REG_DATA, 8'hff);
		push_cmd(CMD_RESET, 0);
		push_data_reads(7);
		pending_reqs.push_back('{1'b1, REG_CONTROL, 8'h00, 8'hff});
		push_cmd(8'h77, 32'hffffffff);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			no_idle = (ph == 3);
			write_cfg(CFG_PRESENT, settings[ph][3]);
			write_cfg(CFG_PROTECT, settings[ph][2]);
			write_cfg(CFG_JUMPER, settings[ph][1]);
			write_cfg(CFG_REVISION, settings[ph][0]);
			if (ph == 1) begin
				push_cmd(CMD_BLEN, 32'hffffffff);
				push_cmd(CMD_READ, 32'hfffffffe);
				push_req(1, REG_CONTROL, 8'h40);
				push_data_reads(5);
				push_cmd(CMD_BLEN, 0);
				push_cmd(CMD_WRITE, 32'h12345678);
				push_data_reads(1);
			end
			while (pending_reqs.size() < PHASE_ITEMS) push_sequence();
			wait_idle();
		end

		$display("covered %0d bus requests, %0d results, %0d storage reads, %0d storage writes",
			n_reqs, n_resps, n_storage_rd, n_storage_wr);
		$display("six card settings including all bits set and card absent");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
